// ----- rtl/aet_pkg.sv -----
// Shared constants, token codes and the queue entry type of the expression tokenizer.
package aet_pkg;

  // Longest number that is kept, in characters.
  localparam int MAX_NUMBER_CHARS = 15;
  // Width of the internal row and column counters.
  localparam int POSITION_BITS = 16;
  // Depth of the queue between the lexer front and the token back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Fixed widths of the token fields.
  localparam int KIND_W = 4;
  localparam int OUT_POS_W = 16;
  localparam int TEXT_W = 60;
  localparam int LEN_W = 4;
  localparam int ERR_W = 2;
  localparam int CHAR_W = 8;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ERR_W-1:0] err_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  // Token kinds.
  localparam kind_t KIND_INT = 4'd0;
  localparam kind_t KIND_FLOAT = 4'd1;
  localparam kind_t KIND_ADD = 4'd2;
  localparam kind_t KIND_SUB = 4'd3;
  localparam kind_t KIND_MUL = 4'd4;
  localparam kind_t KIND_DIV = 4'd5;
  localparam kind_t KIND_MOD = 4'd6;
  localparam kind_t KIND_POW = 4'd7;
  localparam kind_t KIND_LPAREN = 4'd8;
  localparam kind_t KIND_RPAREN = 4'd9;
  localparam kind_t KIND_END = 4'd10;
  localparam kind_t KIND_ERROR = 4'd11;

  // Error codes.
  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_BAD_CHAR = 2'd1;
  localparam err_t ERR_DOTS = 2'd2;
  localparam err_t ERR_TOO_LONG = 2'd3;

  // Work for one input character: an optional finished number followed by an
  // optional further token. Both share the position fields.
  typedef struct packed {
    logic has_num;
    logic num_float;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0] len;
    logic has_tok;
    kind_t tok_kind;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    err_t err;
    logic [CHAR_W-1:0] bad;
  } entry_t;

endpackage

// ----- rtl/aet_front.sv -----
// Lexer front end: accepts characters, tracks position and number state, builds queue entries.
module aet_front (
  input  logic clk,
  input  logic rst,
  input  logic char_valid,
  input  logic char_stall,
  input  logic [aet_pkg::CHAR_W-1:0] char_code,
  output logic push,
  output aet_pkg::entry_t push_entry
);

  localparam int NIDX_W = (aet_pkg::MAX_NUMBER_CHARS > 1) ?
                          $clog2(aet_pkg::MAX_NUMBER_CHARS) : 1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [3:0] DOT_CODE = 4'd10;

  typedef logic [aet_pkg::MAX_NUMBER_CHARS-1:0][3:0] digits_t;

  // Increment that sticks at the top of the counter range.
  function automatic aet_pkg::pos_t sat_inc(input aet_pkg::pos_t v);
    return (v == '1) ? v : v + aet_pkg::pos_t'(1);
  endfunction

  // Operator characters: valid flag and token kind.
  function automatic logic [aet_pkg::KIND_W:0] op_lookup(input logic [7:0] c);
    logic [aet_pkg::KIND_W:0] r;
    case (c)
      CH_PLUS: r = {1'b1, aet_pkg::KIND_ADD};
      CH_MINUS: r = {1'b1, aet_pkg::KIND_SUB};
      CH_STAR: r = {1'b1, aet_pkg::KIND_MUL};
      CH_SLASH: r = {1'b1, aet_pkg::KIND_DIV};
      CH_PERCENT: r = {1'b1, aet_pkg::KIND_MOD};
      CH_CARET: r = {1'b1, aet_pkg::KIND_POW};
      CH_LPAREN: r = {1'b1, aet_pkg::KIND_LPAREN};
      CH_RPAREN: r = {1'b1, aet_pkg::KIND_RPAREN};
      default: r = '0;
    endcase
    return r;
  endfunction

  aet_pkg::pos_t line_count, line_count_next;
  aet_pkg::pos_t column_count, column_count_next;
  logic previous_was_newline, previous_was_newline_next;
  logic inside_number, inside_number_next;
  logic dot_seen, dot_seen_next;
  logic [aet_pkg::LEN_W-1:0] digits_held, digits_held_next;
  digits_t digit_buffer, digit_buffer_next;
  aet_pkg::pos_t number_start_row, number_start_row_next;
  aet_pkg::pos_t number_start_column, number_start_column_next;
  logic halted_on_error, halted_on_error_next;

  logic accept;
  logic is_dig;
  logic is_dot;
  logic is_space;
  logic restart;
  logic [aet_pkg::KIND_W:0] op_info;
  logic [3:0] char_nibble;
  aet_pkg::entry_t entry;

  assign accept = char_valid && !char_stall;
  assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_dot = (char_code == CH_DOT);
  assign is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) || (char_code == CH_LF);
  assign op_info = op_lookup(char_code);
  assign char_nibble = is_dot ? DOT_CODE : char_code[3:0];

  // Classification of one character and the next lexer state.
  always_comb begin
    line_count_next = line_count;
    column_count_next = column_count;
    inside_number_next = inside_number;
    dot_seen_next = dot_seen;
    digits_held_next = digits_held;
    digit_buffer_next = digit_buffer;
    number_start_row_next = number_start_row;
    number_start_column_next = number_start_column;
    halted_on_error_next = halted_on_error;
    restart = 1'b0;
    entry = '0;

    if (previous_was_newline) begin
      line_count_next = sat_inc(line_count);
      column_count_next = aet_pkg::pos_t'(1);
    end else begin
      column_count_next = sat_inc(column_count);
    end
    previous_was_newline_next = (char_code == CH_LF);
    entry.row = aet_pkg::OUT_POS_W'(line_count_next);
    entry.col = aet_pkg::OUT_POS_W'(column_count_next);

    if (halted_on_error) begin
      // Everything but the end of text is dropped after an error.
      if (char_code == CH_NUL) begin
        entry.has_tok = 1'b1;
        entry.tok_kind = aet_pkg::KIND_END;
        restart = 1'b1;
      end
    end else if (inside_number && (is_dig || is_dot)) begin
      if (is_dot && dot_seen) begin
        entry.has_tok = 1'b1;
        entry.tok_kind = aet_pkg::KIND_ERROR;
        entry.err = aet_pkg::ERR_DOTS;
        entry.row = aet_pkg::OUT_POS_W'(number_start_row);
        entry.col = aet_pkg::OUT_POS_W'(number_start_column);
        halted_on_error_next = 1'b1;
        inside_number_next = 1'b0;
        dot_seen_next = 1'b0;
        digits_held_next = '0;
        digit_buffer_next = '0;
      end else if (digits_held >= aet_pkg::LEN_W'(aet_pkg::MAX_NUMBER_CHARS)) begin
        entry.has_tok = 1'b1;
        entry.tok_kind = aet_pkg::KIND_ERROR;
        entry.err = aet_pkg::ERR_TOO_LONG;
        entry.row = aet_pkg::OUT_POS_W'(number_start_row);
        entry.col = aet_pkg::OUT_POS_W'(number_start_column);
        halted_on_error_next = 1'b1;
        inside_number_next = 1'b0;
        dot_seen_next = 1'b0;
        digits_held_next = '0;
        digit_buffer_next = '0;
      end else begin
        digit_buffer_next[digits_held[NIDX_W-1:0]] = char_nibble;
        digits_held_next = digits_held + aet_pkg::LEN_W'(1);
        if (is_dot) begin
          dot_seen_next = 1'b1;
        end
      end
    end else begin
      // A character that ends a number releases it before being handled itself.
      if (inside_number) begin
        entry.has_num = 1'b1;
        entry.num_float = dot_seen;
        entry.text = aet_pkg::TEXT_W'(digit_buffer);
        entry.len = digits_held;
        inside_number_next = 1'b0;
        dot_seen_next = 1'b0;
        digits_held_next = '0;
        digit_buffer_next = '0;
      end
      if (char_code == CH_NUL) begin
        entry.has_tok = 1'b1;
        entry.tok_kind = aet_pkg::KIND_END;
        restart = 1'b1;
      end else if (is_space) begin
        entry.has_tok = 1'b0;
      end else if (op_info[aet_pkg::KIND_W]) begin
        entry.has_tok = 1'b1;
        entry.tok_kind = op_info[aet_pkg::KIND_W-1:0];
      end else if (is_dig) begin
        inside_number_next = 1'b1;
        dot_seen_next = 1'b0;
        digits_held_next = aet_pkg::LEN_W'(1);
        digit_buffer_next = '0;
        digit_buffer_next[0] = char_nibble;
        number_start_row_next = line_count_next;
        number_start_column_next = column_count_next;
      end else begin
        entry.has_tok = 1'b1;
        entry.tok_kind = aet_pkg::KIND_ERROR;
        entry.err = aet_pkg::ERR_BAD_CHAR;
        entry.bad = char_code;
        halted_on_error_next = 1'b1;
      end
    end

    // End of text returns the lexer to its reset state.
    if (restart) begin
      line_count_next = aet_pkg::pos_t'(1);
      column_count_next = '0;
      previous_was_newline_next = 1'b0;
      inside_number_next = 1'b0;
      dot_seen_next = 1'b0;
      digits_held_next = '0;
      digit_buffer_next = '0;
      number_start_row_next = aet_pkg::pos_t'(1);
      number_start_column_next = aet_pkg::pos_t'(1);
      halted_on_error_next = 1'b0;
    end
  end

  assign push = accept && (entry.has_num || entry.has_tok);
  assign push_entry = entry;

  // Lexer state advances on every character transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= aet_pkg::pos_t'(1);
      column_count <= '0;
      previous_was_newline <= 1'b0;
      inside_number <= 1'b0;
      dot_seen <= 1'b0;
      digits_held <= '0;
      digit_buffer <= '0;
      number_start_row <= aet_pkg::pos_t'(1);
      number_start_column <= aet_pkg::pos_t'(1);
      halted_on_error <= 1'b0;
    end else if (accept) begin
      line_count <= line_count_next;
      column_count <= column_count_next;
      previous_was_newline <= previous_was_newline_next;
      inside_number <= inside_number_next;
      dot_seen <= dot_seen_next;
      digits_held <= digits_held_next;
      digit_buffer <= digit_buffer_next;
      number_start_row <= number_start_row_next;
      number_start_column <= number_start_column_next;
      halted_on_error <= halted_on_error_next;
    end
  end

  // A halted lexer never holds a partial number.
  assert property (@(posedge clk) disable iff (rst) halted_on_error |-> !inside_number)
    else $error("aet_front: number held while halted");

endmodule

// ----- rtl/aet_queue.sv -----
// Short queue of lexer entries between the front end and the token back end.
module aet_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  aet_pkg::entry_t push_entry,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output aet_pkg::entry_t head_entry
);

  aet_pkg::entry_t slots [aet_pkg::QUEUE_DEPTH];
  logic [aet_pkg::QPTR_W-1:0] wr_ptr;
  logic [aet_pkg::QPTR_W-1:0] rd_ptr;
  logic [aet_pkg::QCNT_W-1:0] count;

  assign full = (count == aet_pkg::QCNT_W'(aet_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == aet_pkg::QPTR_W'(aet_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + aet_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == aet_pkg::QPTR_W'(aet_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + aet_pkg::QPTR_W'(1);
      end
      count <= count + aet_pkg::QCNT_W'(push) - aet_pkg::QCNT_W'(pop);
    end
  end

  // Never read past the last entry, never write over an unread one.
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("aet_queue: pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("aet_queue: push into full queue");

endmodule

// ----- rtl/aet_back.sv -----
// Token back end: turns queue entries into one or two output tokens through an output register.
module aet_back (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  aet_pkg::entry_t head_entry,
  output logic pop,
  output logic token_valid,
  input  logic token_stall,
  output aet_pkg::kind_t token_kind,
  output logic [aet_pkg::OUT_POS_W-1:0] token_row,
  output logic [aet_pkg::OUT_POS_W-1:0] token_column,
  output logic [aet_pkg::TEXT_W-1:0] number_text,
  output logic [aet_pkg::LEN_W-1:0] number_length,
  output aet_pkg::err_t error_code,
  output logic [aet_pkg::CHAR_W-1:0] bad_character,
  output logic last_of_run
);

  logic phase;
  logic load;
  logic take;
  logic second;

  // The output register loads when empty or when its token is transferred.
  assign load = !token_valid || !token_stall;
  assign take = load && head_valid;
  assign second = phase || !head_entry.has_num;
  assign pop = take && (second || !head_entry.has_tok);

  // Output valid and the number-then-token phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      token_valid <= head_valid;
      if (take) begin
        phase <= !second && head_entry.has_tok;
      end
    end
  end

  // Token payload.
  always_ff @(posedge clk) begin
    if (take) begin
      token_row <= head_entry.row;
      token_column <= head_entry.col;
      if (!second) begin
        token_kind <= head_entry.num_float ? aet_pkg::KIND_FLOAT : aet_pkg::KIND_INT;
        number_text <= head_entry.text;
        number_length <= head_entry.len;
        error_code <= aet_pkg::ERR_NONE;
        bad_character <= '0;
        last_of_run <= !head_entry.has_tok;
      end else begin
        token_kind <= head_entry.tok_kind;
        number_text <= '0;
        number_length <= '0;
        error_code <= head_entry.err;
        bad_character <= head_entry.bad;
        last_of_run <= 1'b1;
      end
    end
  end

  // The second token of a pair is always ready straight after the first.
  assert property (@(posedge clk) disable iff (rst)
    (token_valid && !token_stall && !last_of_run) |=> token_valid)
    else $error("aet_back: gap inside a token pair");
  // While the pair is split, its entry stays at the queue head.
  assert property (@(posedge clk) disable iff (rst) phase |-> head_valid)
    else $error("aet_back: pending second token without entry");

endmodule

// ----- rtl/arithmetic_expression_tokenizer.sv -----
// An accepted character's entry passes through the queue and then the output register.
// One character per cycle unless the queue is full; a character giving a number and
// a token yields two tokens, absorbed by the entry queue between front and back end.
// The lexer front end updates position and number state on each accepted character.
// Reset (rst, synchronous) returns to row 1, column 0, empties the queue and output.
// Top level of the arithmetic expression tokenizer.
module arithmetic_expression_tokenizer (
  input  logic clk,
  input  logic rst,
  input  logic char_valid,
  output logic char_stall,
  input  logic [aet_pkg::CHAR_W-1:0] char_code,
  output logic token_valid,
  input  logic token_stall,
  output logic [aet_pkg::KIND_W-1:0] token_kind,
  output logic [aet_pkg::OUT_POS_W-1:0] token_row,
  output logic [aet_pkg::OUT_POS_W-1:0] token_column,
  output logic [aet_pkg::TEXT_W-1:0] number_text,
  output logic [aet_pkg::LEN_W-1:0] number_length,
  output logic [aet_pkg::ERR_W-1:0] error_code,
  output logic [aet_pkg::CHAR_W-1:0] bad_character,
  output logic last_of_run
);

  logic push;
  aet_pkg::entry_t push_entry;
  logic pop;
  logic full;
  logic head_valid;
  aet_pkg::entry_t head_entry;

  // Characters wait only when the queue is full.
  assign char_stall = full;

  aet_front u_front (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_code(char_code),
    .push(push),
    .push_entry(push_entry)
  );

  aet_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .full(full),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  aet_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .pop(pop),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_kind(token_kind),
    .token_row(token_row),
    .token_column(token_column),
    .number_text(number_text),
    .number_length(number_length),
    .error_code(error_code),
    .bad_character(bad_character),
    .last_of_run(last_of_run)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the arithmetic expression tokenizer.
`timescale 1ns / 100ps

module tb_top;
  import aet_pkg::*;

  // Character codes that the lexer treats specially.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT = ".";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR = "*";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_CARET = "^";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [3:0] DOT_NIBBLE = 4'd10;
  localparam pos_t POS_MAX = '1;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    kind_t kind;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0] len;
    err_t err;
    logic [CHAR_W-1:0] bad;
    logic last;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  logic [CHAR_W-1:0] char_code = '0;
  logic token_valid;
  logic token_stall = 1'b0;
  logic [KIND_W-1:0] token_kind;
  logic [OUT_POS_W-1:0] token_row;
  logic [OUT_POS_W-1:0] token_column;
  logic [TEXT_W-1:0] number_text;
  logic [LEN_W-1:0] number_length;
  logic [ERR_W-1:0] error_code;
  logic [CHAR_W-1:0] bad_character;
  logic last_of_run;

  // Lexer state as the predictor sees it.
  pos_t line_pos;
  pos_t col_pos;
  logic prev_newline;
  logic in_number;
  int dots_seen;
  int digits_held;
  logic [TEXT_W-1:0] digit_text;
  pos_t num_row;
  pos_t num_col;
  logic halted;

  token_t pending_tokens[$];
  int mismatch_count = 0;
  int chars_sent = 0;
  int live_chars = 0;
  int tokens_checked = 0;
  int numbers_seen = 0;
  int errors_seen = 0;
  int ends_seen = 0;
  logic src_idle_on = 1'b0;
  logic sink_idle_on = 1'b0;

  arithmetic_expression_tokenizer u_top (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_code(char_code),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_kind(token_kind),
    .token_row(token_row),
    .token_column(token_column),
    .number_text(number_text),
    .number_length(number_length),
    .error_code(error_code),
    .bad_character(bad_character),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The generous upper bound on the run.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  function automatic pos_t step_pos(input pos_t p);
    return (p == POS_MAX) ? POS_MAX : p + 1'b1;
  endfunction

  function automatic token_t make_token(input kind_t kind, input pos_t row, input pos_t col,
                                        input logic [TEXT_W-1:0] text, input int len,
                                        input err_t err, input logic [7:0] bad);
    token_t t;
    t.kind = kind;
    t.row = row[OUT_POS_W-1:0];
    t.col = col[OUT_POS_W-1:0];
    t.text = text;
    t.len = len[LEN_W-1:0];
    t.err = err;
    t.bad = bad;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic void drop_number();
    in_number = 1'b0;
    dots_seen = 0;
    digits_held = 0;
    digit_text = '0;
  endfunction

  function automatic void clear_lexer();
    line_pos = 1;
    col_pos = 0;
    prev_newline = 1'b0;
    drop_number();
    num_row = 1;
    num_col = 1;
    halted = 1'b0;
  endfunction

  // Works out the tokens that one accepted character gives and queues them.
  function automatic void lex_char(input logic [7:0] c);
    token_t made[$];
    logic digit_char;
    logic is_dot;
    logic is_op;
    kind_t op_kind;
    pos_t row;
    pos_t col;
    digit_char = (c >= CH_ZERO) && (c <= CH_NINE);
    is_dot = (c == CH_DOT);

    // Position of this character.
    if (prev_newline) begin
      line_pos = step_pos(line_pos);
      col_pos = 1;
    end else begin
      col_pos = step_pos(col_pos);
    end
    prev_newline = (c == CH_NEWLINE);
    row = line_pos;
    col = col_pos;

    if (halted) begin
      // Only the end of the text gets through after an error.
      if (c == CH_NUL) begin
        made.push_back(make_token(KIND_END, row, col, '0, 0, ERR_NONE, 8'h00));
        clear_lexer();
      end
    end else if (in_number && (digit_char || is_dot)) begin
      // Growing a number, or breaking it.
      if (is_dot && dots_seen != 0) begin
        made.push_back(make_token(KIND_ERROR, num_row, num_col, '0, 0, ERR_DOTS, 8'h00));
        drop_number();
        halted = 1'b1;
      end else if (digits_held >= MAX_NUMBER_CHARS) begin
        made.push_back(make_token(KIND_ERROR, num_row, num_col, '0, 0, ERR_TOO_LONG, 8'h00));
        drop_number();
        halted = 1'b1;
      end else begin
        digit_text[4*digits_held +: 4] = is_dot ? DOT_NIBBLE : c[3:0];
        digits_held++;
        if (is_dot) dots_seen++;
      end
    end else begin
      // A number ended by any other character is emitted first.
      if (in_number) begin
        made.push_back(make_token((dots_seen != 0) ? KIND_FLOAT : KIND_INT, row, col,
                                  digit_text, digits_held, ERR_NONE, 8'h00));
        drop_number();
      end
      is_op = 1'b1;
      op_kind = KIND_ADD;
      case (c)
        CH_PLUS: op_kind = KIND_ADD;
        CH_MINUS: op_kind = KIND_SUB;
        CH_STAR: op_kind = KIND_MUL;
        CH_SLASH: op_kind = KIND_DIV;
        CH_PERCENT: op_kind = KIND_MOD;
        CH_CARET: op_kind = KIND_POW;
        CH_LPAREN: op_kind = KIND_LPAREN;
        CH_RPAREN: op_kind = KIND_RPAREN;
        default: is_op = 1'b0;
      endcase
      if (c == CH_NUL) begin
        made.push_back(make_token(KIND_END, row, col, '0, 0, ERR_NONE, 8'h00));
        clear_lexer();
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
        // White space gives nothing.
      end else if (is_op) begin
        made.push_back(make_token(op_kind, row, col, '0, 0, ERR_NONE, 8'h00));
      end else if (digit_char) begin
        in_number = 1'b1;
        dots_seen = 0;
        digits_held = 1;
        digit_text = '0;
        digit_text[3:0] = c[3:0];
        num_row = row;
        num_col = col;
      end else begin
        made.push_back(make_token(KIND_ERROR, row, col, '0, 0, ERR_BAD_CHAR, c));
        halted = 1'b1;
      end
    end

    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) pending_tokens.push_back(made[i]);
  endfunction

  // ------------------------------------------------------------------
  // Driving and checking
  // ------------------------------------------------------------------

  // Sends one character and predicts its tokens once the transfer is taken.
  task automatic send_char(input logic [7:0] c);
    if (src_idle_on) begin
      while ($urandom_range(99) < 35) begin
        char_valid <= 1'b0;
        char_code <= 8'($urandom);
        @(posedge clk);
      end
    end
    char_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (char_stall);
    chars_sent++;
    if (!halted) live_chars++;
    lex_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Sends a number of the given length with up to two dots after the first digit.
  task automatic send_number(input int len, input int dots);
    int dot_a;
    int dot_b;
    dot_a = -1;
    dot_b = -1;
    if (dots > 0 && len >= 2) dot_a = $urandom_range(1, len - 1);
    if (dots > 1 && len >= 3) begin
      dot_b = $urandom_range(1, len - 1);
      if (dot_b == dot_a) dot_b = (dot_a == len - 1) ? 1 : dot_a + 1;
    end
    for (int i = 0; i < len; i++) begin
      send_char((i == dot_a || i == dot_b) ? CH_DOT : CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Compares one token transfer with the oldest expectation.
  task automatic check_token();
    token_t want;
    if (pending_tokens.size() == 0) begin
      report_mismatch("unexpected token (kind shown)", 64'(token_kind), 64'(0));
    end else begin
      want = pending_tokens.pop_front();
      tokens_checked++;
      if (want.kind == KIND_INT || want.kind == KIND_FLOAT) numbers_seen++;
      if (want.kind == KIND_ERROR) errors_seen++;
      if (want.kind == KIND_END) ends_seen++;
      if (token_kind !== want.kind) report_mismatch("token_kind", 64'(token_kind), 64'(want.kind));
      if (token_row !== want.row) report_mismatch("token_row", 64'(token_row), 64'(want.row));
      if (token_column !== want.col) begin
        report_mismatch("token_column", 64'(token_column), 64'(want.col));
      end
      if (number_text !== want.text) begin
        report_mismatch("number_text", 64'(number_text), 64'(want.text));
      end
      if (number_length !== want.len) begin
        report_mismatch("number_length", 64'(number_length), 64'(want.len));
      end
      if (error_code !== want.err) report_mismatch("error_code", 64'(error_code), 64'(want.err));
      if (bad_character !== want.bad) begin
        report_mismatch("bad_character", 64'(bad_character), 64'(want.bad));
      end
      if (last_of_run !== want.last) begin
        report_mismatch("last_of_run", 64'(last_of_run), 64'(want.last));
      end
    end
  endtask

  // Output side stalls at random while enabled.
  always @(posedge clk) begin
    token_stall <= sink_idle_on && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) check_token();
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Every operator, every kind of white space, and the end of text.
  task automatic test_operators_and_spacing();
    send_text("+-*/%^()");
    send_text(" \t\n");
    send_text("(\n)");
    send_char(CH_NUL);
  endtask

  // Integers and floats, the longest legal number, and NUL inside a number.
  task automatic test_numbers();
    send_text("0 9876543210+3.14)");
    send_text("123456789012345");
    send_char(CH_NUL);
    send_text("1.2345678901234 ");
    send_char(CH_NUL);
  endtask

  // Second dot, numbers that grow too long, and a dot with no number before it.
  task automatic test_number_errors();
    send_text("1.2.5+");
    send_char(CH_NUL);
    send_text("1234567890123456");
    send_char(CH_NUL);
    send_text("123456789012345.");
    send_char(CH_NUL);
    send_text("1.2345678901234.");
    send_char(CH_NUL);
    send_text(".5");
    send_char(CH_NUL);
  endtask

  // Invalid bytes, a number ended by one, and the halt that follows.
  task automatic test_invalid_characters();
    send_text("7a");
    send_char(CH_NUL);
    send_char(8'hFF);
    send_char(CH_NUL);
    send_text("@ (\n9");
    send_char(CH_NUL);
  endtask

  // Mostly well-formed expressions with random content, plus noise and broken numbers.
  task automatic test_random_text();
    string op_chars;
    string space_chars;
    int base;
    int roll;
    op_chars = "+-*/%^()";
    space_chars = " \t\n";
    base = live_chars;
    src_idle_on = 1'b0;
    sink_idle_on <= 1'b0;
    while (live_chars - base < RANDOM_ITEMS) begin
      // The first quarter runs with no idling; later texts pick their own.
      if (live_chars - base > RANDOM_ITEMS / 4) begin
        src_idle_on = ($urandom_range(3) != 0);
        sink_idle_on <= ($urandom_range(3) != 0);
      end
      repeat ($urandom_range(1, 16)) begin
        roll = $urandom_range(99);
        if (roll < 40) begin
          send_number(($urandom_range(4) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6),
                      ($urandom_range(2) == 0) ? 1 : 0);
        end else if (roll < 68) begin
          send_char(op_chars[$urandom_range(7)]);
        end else if (roll < 84) begin
          send_char(space_chars[$urandom_range(2)]);
        end else if (roll < 90) begin
          send_char(8'($urandom_range(1, 255)));
        end else if (roll < 94) begin
          send_number($urandom_range(16, 18), 0);
        end else if (roll < 97) begin
          send_number($urandom_range(3, 15), 2);
        end else begin
          send_char(CH_DOT);
        end
      end
      send_char(CH_NUL);
    end
  endtask

  initial begin
    clear_lexer();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on <= 1'b1;
    @(posedge clk);

    test_operators_and_spacing();
    test_numbers();
    test_number_errors();
    test_invalid_characters();
    test_random_text();

    // Drain the remaining tokens, then watch for stray ones.
    char_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters (%0d outside halted spans) and checked %0d tokens:",
             chars_sent, live_chars, tokens_checked);
    $display("  %0d numbers, %0d errors, %0d end tokens; %0d mismatches.",
             numbers_seen, errors_seen, ends_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/aet_pkg.sv
rtl/aet_front.sv
rtl/aet_queue.sv
rtl/aet_back.sv
rtl/arithmetic_expression_tokenizer.sv
verif/tb_top.sv
